// ===== hdl/nbrr_pkg.sv =====
// Shared types and constants of the non-uniform bearing row resampler.
package nbrr_pkg;

    // Field widths fixed by the request and result formats.
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 9;
    localparam int ANGLE_W  = 16;
    localparam int SAMPLE_W = 8;
    localparam int COUNT_W  = 10;

    // Interpolation arithmetic: numerator y0*(x1-a) + y1*(a-x0) and an 8-bit quotient.
    localparam int NUM_W = SAMPLE_W + ANGLE_W;
    localparam int QUO_W = SAMPLE_W;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_BEARING = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TARGET  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [INDEX_W-1:0]         index;
        logic signed [ANGLE_W-1:0]  angle;
        logic [SAMPLE_W-1:0]        sample;
        logic                       row_start;
    } nbrr_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                covered;
    } nbrr_out_t;

endpackage

// ===== hdl/nbrr_div.sv =====
// Restoring divider with half-up rounding for the interpolation quotient.
module nbrr_div import nbrr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [ANGLE_W-1:0] den,
    output logic               done,
    output logic [QUO_W-1:0]   quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   dsh_reg;
    logic [ANGLE_W-1:0] den_reg;
    logic [QUO_W-1:0]   quo_reg;

    logic             iterate;
    logic             finish;
    logic             bit_ge;
    logic             round_up;

    // The quotient is known to be below 2^QUO_W, so QUO_W trial subtractions suffice.
    assign iterate  = busy_reg && (cnt_reg < CNT_W'(QUO_W));
    assign finish   = busy_reg && (cnt_reg == CNT_W'(QUO_W));
    assign bit_ge   = rem_reg >= dsh_reg;
    assign round_up = (NUM_W+1)'({rem_reg, 1'b0}) >= (NUM_W+1)'(den_reg);

    // Control sequencing.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (iterate) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (finish) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Remainder, shifted divisor and quotient: one quotient bit per cycle, then rounding.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
            dsh_reg <= NUM_W'(den) << (QUO_W - 1);
            quo_reg <= '0;
        end else if (iterate) begin
            if (bit_ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], bit_ge};
        end else if (finish) begin
            // The exact value never exceeds the larger sample, so this cannot overflow.
            if (round_up) begin
                quo_reg <= quo_reg + QUO_W'(1);
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/nbrr_core.sv =====
// Table and row stores with the segment walk and interpolation sequencer.
module nbrr_core import nbrr_pkg::*; #(
    parameter int MAX_BEAMS = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  nbrr_in_t           in_data,
    input  logic [COUNT_W-1:0] point_count,
    output logic               res_valid,
    input  logic               res_ready,
    output nbrr_out_t          res_data
);

    localparam int AW = $clog2(MAX_BEAMS);
    localparam int EW = ((COUNT_W > AW + 1) ? COUNT_W : AW + 1) + 1;
    localparam int LW = (INDEX_W > AW + 1) ? INDEX_W : AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_LOW  = 3'd3;
    localparam logic [2:0] S_MUL0 = 3'd4;
    localparam logic [2:0] S_MUL1 = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          pe_reg, pe_next;

    // Stores and their registered read data.
    logic signed [ANGLE_W-1:0] tab_mem [MAX_BEAMS];
    logic [SAMPLE_W-1:0]       row_mem [MAX_BEAMS];
    logic signed [ANGLE_W-1:0] tab_q;
    logic [SAMPLE_W-1:0]       row_q;

    // Item payload and operands.
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [ANGLE_W-1:0] x1_reg;
    logic [SAMPLE_W-1:0]       y0_reg;
    logic [SAMPLE_W-1:0]       y1_reg;
    logic [ANGLE_W-1:0]        t_reg;
    logic [ANGLE_W-1:0]        u_reg;
    logic [ANGLE_W-1:0]        d_reg;
    logic [NUM_W-1:0]          acc_reg;
    nbrr_out_t                 res_reg;

    logic          accept;
    logic [LW-1:0] idx_ext;
    logic          idx_ok;
    logic [AW-1:0] wr_addr;
    logic          tab_we;
    logic          row_we;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [EW-1:0] pc_ext;
    logic [EW-1:0] n_eff;
    logic [EW-1:0] ptr_inc_ext;
    logic [AW-1:0] ptr_inc;
    logic          end_hit;
    logic          advance;
    logic          below;

    logic signed [ANGLE_W:0] d_full;
    logic signed [ANGLE_W:0] t_full;
    logic signed [ANGLE_W:0] u_full;

    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic             div_done;
    logic [QUO_W-1:0] div_quo;

    // Load decode: a load beyond the store depth is dropped.
    assign accept  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign idx_ext = LW'(in_data.index);
    assign idx_ok  = idx_ext < LW'(MAX_BEAMS);
    assign wr_addr = AW'(idx_ext);
    assign tab_we  = accept && (in_data.kind == KIND_BEARING) && idx_ok;
    assign row_we  = accept && (in_data.kind == KIND_SAMPLE) && idx_ok;

    // Effective point count, clamped to two and to the store depth.
    assign pc_ext = EW'(point_count);
    always_comb begin
        if (pc_ext < EW'(2)) begin
            n_eff = EW'(2);
        end else if (pc_ext > EW'(MAX_BEAMS)) begin
            n_eff = EW'(MAX_BEAMS);
        end else begin
            n_eff = pc_ext;
        end
    end

    assign ptr_inc_ext = EW'(ptr_reg) + EW'(1);
    assign ptr_inc     = AW'(ptr_inc_ext);
    assign end_hit     = ptr_inc_ext >= n_eff;
    assign advance     = angle_reg >= tab_q;
    assign below       = angle_reg < tab_q;

    // Segment geometry; the target lies in [x0, x1) so both parts fit unsigned.
    assign d_full = {x1_reg[ANGLE_W-1], x1_reg} - {tab_q[ANGLE_W-1], tab_q};
    assign t_full = {angle_reg[ANGLE_W-1], angle_reg} - {tab_q[ANGLE_W-1], tab_q};
    assign u_full = {x1_reg[ANGLE_W-1], x1_reg} - {angle_reg[ANGLE_W-1], angle_reg};

    // Sequencer: walk the pointer, fetch the segment ends, multiply, divide.
    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        pe_next    = pe_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept && (in_data.kind == KIND_TARGET)) begin
                    if (in_data.row_start) begin
                        ptr_next = '0;
                        pe_next  = 1'b0;
                    end
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                if (pe_reg) begin
                    state_next = S_OUT;
                end else if (end_hit) begin
                    pe_next    = 1'b1;
                    state_next = S_OUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_inc;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (advance) begin
                    ptr_next   = ptr_inc;
                    state_next = S_STEP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg;
                    state_next = S_LOW;
                end
            end
            S_LOW: begin
                // Above x0 and below x1 implies a positive segment width.
                if (below) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0: begin
                state_next = S_MUL1;
            end
            S_MUL1: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            pe_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            pe_reg    <= pe_next;
        end
    end

    // Store writes and registered reads; loads and reads never share a cycle.
    always_ff @(posedge aclk) begin
        if (tab_we) begin
            tab_mem[wr_addr] <= in_data.angle;
        end
        if (row_we) begin
            row_mem[wr_addr] <= in_data.sample;
        end
        if (rd_en) begin
            tab_q <= tab_mem[rd_addr];
            row_q <= row_mem[rd_addr];
        end
    end

    // Second product folded into the divider load.
    assign div_num = acc_reg + NUM_W'(NUM_W'(y1_reg) * NUM_W'(t_reg));

    // Operand and result registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            angle_reg <= in_data.angle;
        end
        case (state_reg)
            S_STEP: begin
                res_reg <= '0;
            end
            S_CMP: begin
                x1_reg <= tab_q;
                y1_reg <= row_q;
            end
            S_LOW: begin
                res_reg <= '0;
                y0_reg  <= row_q;
                d_reg   <= d_full[ANGLE_W-1:0];
                t_reg   <= t_full[ANGLE_W-1:0];
                u_reg   <= u_full[ANGLE_W-1:0];
            end
            S_MUL0: begin
                acc_reg <= NUM_W'(y0_reg) * NUM_W'(u_reg);
            end
            S_DIV: begin
                if (div_done) begin
                    res_reg.value   <= div_quo;
                    res_reg.covered <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    nbrr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (d_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign res_valid = (state_reg == S_OUT);
    assign res_data  = res_reg;

endmodule

// ===== hdl/nonuniform_bearing_row_resampler.sv =====
// Top level of the non-uniform bearing row resampler.
//
// Requests enter on the s_ channel (valid/ready) and carry one of three kinds:
// a bearing table load, a row sample load, or a target bearing to resample.
// Loads give no result and leave the block idle. A target gives one result on
// the m_ channel: the row intensity linearly interpolated between the two
// neighbouring bearings, rounded half up, or zero with covered low when the
// target lies below the current segment or at or past the last bearing.
// A target occupies the block until its result moves to the output register:
// each segment the pointer advances over costs a store read and a compare,
// then the two segment ends are fetched, two products are formed and the
// restoring divider runs (eight quotient steps and a rounding step).
// Targets past the end or below the current segment skip the products
// and the divider. The user must write point_count through cfg_wr_en/cfg_wr_data
// only while the block idles; the block itself leaves this unchecked.
// Reset clears the segment pointer, the past-end flag and the output stage and
// sets point_count to min(MAX_BEAMS, 1023); stores are undefined until loaded.
// When the receiver stalls, one finished result waits in the output register
// and loads are still accepted; the next target then waits for that slot.
module nonuniform_bearing_row_resampler import nbrr_pkg::*; #(
    parameter int MAX_BEAMS = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nbrr_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output nbrr_out_t          m_data,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data
);

    localparam logic [COUNT_W-1:0] PC_RESET =
        (MAX_BEAMS > 1023) ? COUNT_W'(1023) : COUNT_W'(MAX_BEAMS);

    logic [COUNT_W-1:0] pc_reg;
    logic               m_valid_reg, m_valid_next;
    nbrr_out_t          m_data_reg;

    logic      res_valid;
    logic      res_ready;
    nbrr_out_t res_data;

    // Point count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_RESET;
        end else if (cfg_wr_en) begin
            pc_reg <= cfg_wr_data;
        end
    end

    nbrr_core #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .point_count (pc_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    // Output register decouples the receiver from the sequencer.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/nbrr_chk.sv =====
// Port-level assertions for the resampler and their binding to the top level.
module nbrr_chk import nbrr_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input nbrr_in_t           s_data,
    input logic               m_valid,
    input logic               m_ready,
    input nbrr_out_t          m_data
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output stage.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An uncovered target always reads as zero.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.covered |-> m_data.value == '0)
        else $error("uncovered result with non-zero value");

    // A target request holds off further requests in the cycle after its acceptance.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == KIND_TARGET) |=> !s_ready)
        else $error("request taken in the cycle after a target");

endmodule

bind nonuniform_bearing_row_resampler nbrr_chk u_nbrr_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);
